>>> rtl/pid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_pkg: shared types and codes for the positional insert deque
// Operation codes, status codes, cell commands and storage widths used by the
// cell chain and the top level.
// ----------------------------------------------------------------------------
package pid_pkg;

   // Storage geometry
   localparam int CAPACITY = 32;
   localparam int WORD_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int REQ_IDX_W = 6;
   localparam int ENT_W    = 6;
   localparam int CMP_W    = (CNT_W > REQ_IDX_W) ? CNT_W : REQ_IDX_W;

   // Stream payload widths (whole bytes)
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [CMP_W-1:0]     cmp_type;
   typedef logic [ENT_W-1:0]     ent_type;

   // Operation codes carried by each request transaction
   localparam logic [2:0] MODE_PUSH_TAIL = 3'd0;
   localparam logic [2:0] MODE_PUSH_HEAD = 3'd1;
   localparam logic [2:0] MODE_INSERT    = 3'd2;
   localparam logic [2:0] MODE_POP_HEAD  = 3'd3;
   localparam logic [2:0] MODE_POP_TAIL  = 3'd4;
   localparam logic [2:0] MODE_CLEAR     = 3'd5;
   localparam logic [2:0] MODE_DUMP      = 3'd6;

   // Status codes returned with each response
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_INDEX = 2'd3;

   // Commands broadcast to every cell
   localparam logic [1:0] CELL_HOLD  = 2'd0;  // keep stored word
   localparam logic [1:0] CELL_INS   = 2'd1;  // open a gap at pos, load value there
   localparam logic [1:0] CELL_SHDN  = 2'd2;  // take the word from the cell above
   localparam logic [1:0] CELL_ROT   = 2'd3;  // shift down below pos, head wraps to pos

   typedef struct packed {
      logic [1:0] op;
      idx_type    pos;
      word_type   value;
   } cell_cmd_type;

endpackage

>>> rtl/pid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_cell: one storage cell of the deque chain
// Holds one word and, on each command, keeps it or takes a word from its
// lower neighbor, its upper neighbor, the head cell or the request value.
// ----------------------------------------------------------------------------
module pid_cell (
   input  logic                  clock,
   input  pid_pkg::cell_cmd_type cmd,
   input  pid_pkg::idx_type      cell_pos,    // this cell's place in the chain
   input  pid_pkg::word_type     lower_word,  // word of the cell one place nearer the head
   input  pid_pkg::word_type     upper_word,  // word of the cell one place nearer the tail
   input  pid_pkg::word_type     head_word,   // word of cell zero
   output pid_pkg::word_type     word
);

   pid_pkg::word_type word_ff;
   pid_pkg::word_type word_in;

   // Pick the next word from the broadcast command and this cell's place
   always_comb begin
      word_in = word_ff;
      case (cmd.op)
         pid_pkg::CELL_INS: begin
            if (cell_pos > cmd.pos) begin
               word_in = lower_word;
            end else if (cell_pos == cmd.pos) begin
               word_in = cmd.value;
            end
         end
         pid_pkg::CELL_SHDN: begin
            word_in = upper_word;
         end
         pid_pkg::CELL_ROT: begin
            if (cell_pos < cmd.pos) begin
               word_in = upper_word;
            end else if (cell_pos == cmd.pos) begin
               word_in = head_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   // Payload register, no reset needed
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

>>> rtl/positional_insert_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_deque: bounded ordered list of signed 32-bit words
// A chain of storage cells with push at head or tail, insert at a position,
// pop at head or tail, clear and an in-order dump.
// ----------------------------------------------------------------------------
// Usage:
//   Each request transaction carries one operation (mode), a value and an
//   insert index in req_tdata. Responses leave on the rsp_ channel with a
//   status, a word, the entry count after the operation and rsp_tlast on the
//   final response of the request.
//   For push, insert, pop, clear and no-op, any shift of the cell chain and
//   the response register load happen on acceptance. A new request is
//   taken every cycle while the response register drains, so the sustained
//   rate is one request per cycle.
//   A dump of N entries gives N responses: the chain rotates one place per
//   response and the head cell feeds the output, so the list is back in its
//   original order when the last response leaves. req_tready stays low
//   during a dump. An empty dump gives a single response.
//   If rsp_tready is low while a response is held, the response register
//   holds and no new request or dump step advances until it is taken.
//   Reset (synchronous, active high) empties the list and drops any pending
//   response; the stored words themselves are not cleared.
// ----------------------------------------------------------------------------
module positional_insert_deque (
   input  logic                               clock,
   input  logic                               reset,
   // Request: mode[2:0], value[34:3], index[40:35], zero[47:41]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pid_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Response: status[1:0], word[33:2], entries[39:34]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pid_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   // Request fields
   logic [2:0]                       req_mode;
   pid_pkg::word_type                req_value;
   logic [pid_pkg::REQ_IDX_W-1:0]    req_index;

   assign req_mode  = req_tdata[2:0];
   assign req_value = req_tdata[34:3];
   assign req_index = req_tdata[40:35];

   // Control and response registers
   logic                  state_ff, state_in;
   pid_pkg::cnt_type      count_ff, count_in;
   pid_pkg::cnt_type      remain_ff, remain_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   pid_pkg::word_type     rsp_word_ff, rsp_word_in;
   logic                  rsp_last_ff, rsp_last_in;
   pid_pkg::ent_type      rsp_entries_ff, rsp_entries_in;

   logic                  out_free;
   logic                  req_fire;
   pid_pkg::idx_type      tail_pos;
   pid_pkg::word_type     tail_word;
   pid_pkg::cell_cmd_type cmd;

   pid_pkg::word_type     cell_word  [pid_pkg::CAPACITY];
   pid_pkg::word_type     lower_word [pid_pkg::CAPACITY];
   pid_pkg::word_type     upper_word [pid_pkg::CAPACITY];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign tail_pos   = pid_pkg::idx_type'(count_ff - pid_pkg::cnt_type'(1));

   // Cell chain
   for (genvar i = 0; i < pid_pkg::CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign lower_word[i] = '0;
      end else begin : g_body
         assign lower_word[i] = cell_word[i-1];
      end
      if (i == pid_pkg::CAPACITY - 1) begin : g_top
         assign upper_word[i] = '0;
      end else begin : g_below
         assign upper_word[i] = cell_word[i+1];
      end

      pid_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_pos   (pid_pkg::idx_type'(i)),
         .lower_word (lower_word[i]),
         .upper_word (upper_word[i]),
         .head_word  (cell_word[0]),
         .word       (cell_word[i])
      );
   end

   // Select the tail word for pop tail
   always_comb begin
      tail_word = '0;
      for (int i = 0; i < pid_pkg::CAPACITY; i++) begin
         if (pid_pkg::idx_type'(i) == tail_pos) begin
            tail_word = cell_word[i];
         end
      end
   end

   // Decode the request or advance the dump
   always_comb begin
      cmd.op         = pid_pkg::CELL_HOLD;
      cmd.pos        = '0;
      cmd.value      = req_value;
      count_in       = count_ff;
      state_in       = state_ff;
      remain_in      = remain_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_entries_in = rsp_entries_ff;

      if (req_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pid_pkg::STATUS_OK;
         rsp_word_in   = '0;
         rsp_last_in   = 1'b1;
         unique case (req_mode) inside
            pid_pkg::MODE_PUSH_TAIL, pid_pkg::MODE_PUSH_HEAD, pid_pkg::MODE_INSERT: begin
               if (count_ff >= pid_pkg::cnt_type'(pid_pkg::CAPACITY)) begin
                  rsp_status_in = pid_pkg::STATUS_FULL;
               end else if (req_mode == pid_pkg::MODE_INSERT &&
                            pid_pkg::cmp_type'(req_index) > pid_pkg::cmp_type'(count_ff)) begin
                  rsp_status_in = pid_pkg::STATUS_INDEX;
               end else begin
                  cmd.op = pid_pkg::CELL_INS;
                  if (req_mode == pid_pkg::MODE_PUSH_TAIL) begin
                     cmd.pos = pid_pkg::idx_type'(count_ff);
                  end else if (req_mode == pid_pkg::MODE_PUSH_HEAD) begin
                     cmd.pos = '0;
                  end else begin
                     cmd.pos = pid_pkg::idx_type'(req_index);
                  end
                  count_in = count_ff + pid_pkg::cnt_type'(1);
               end
            end
            pid_pkg::MODE_POP_HEAD: begin
               if (count_ff == '0) begin
                  rsp_status_in = pid_pkg::STATUS_EMPTY;
               end else begin
                  cmd.op      = pid_pkg::CELL_SHDN;
                  rsp_word_in = cell_word[0];
                  count_in    = count_ff - pid_pkg::cnt_type'(1);
               end
            end
            pid_pkg::MODE_POP_TAIL: begin
               if (count_ff == '0) begin
                  rsp_status_in = pid_pkg::STATUS_EMPTY;
               end else begin
                  rsp_word_in = tail_word;
                  count_in    = count_ff - pid_pkg::cnt_type'(1);
               end
            end
            pid_pkg::MODE_CLEAR: begin
               count_in = '0;
            end
            pid_pkg::MODE_DUMP: begin
               if (count_ff == '0) begin
                  rsp_status_in = pid_pkg::STATUS_EMPTY;
               end else begin
                  // hand the responses to the dump walk
                  rsp_valid_in = 1'b0;
                  remain_in    = count_ff;
                  state_in     = ST_DUMP;
               end
            end
            default: begin
               rsp_status_in = pid_pkg::STATUS_OK;
            end
         endcase
         rsp_entries_in = pid_pkg::ent_type'(count_in);
      end else if (state_ff == ST_DUMP && out_free) begin
         // emit the head word and rotate it behind the tail
         cmd.op         = pid_pkg::CELL_ROT;
         cmd.pos        = tail_pos;
         rsp_valid_in   = 1'b1;
         rsp_status_in  = pid_pkg::STATUS_OK;
         rsp_word_in    = cell_word[0];
         rsp_last_in    = (remain_ff == pid_pkg::cnt_type'(1));
         rsp_entries_in = pid_pkg::ent_type'(count_ff);
         remain_in      = remain_ff - pid_pkg::cnt_type'(1);
         if (remain_ff == pid_pkg::cnt_type'(1)) begin
            state_in = ST_IDLE;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_word_ff    <= rsp_word_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_entries_ff <= rsp_entries_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_entries_ff, rsp_word_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // Count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pid_pkg::cnt_type'(pid_pkg::CAPACITY))
      else $error("entry count above capacity");

   // No request is taken while a dump walks the chain
   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> !req_tready)
      else $error("request taken during dump");

   // The final dump step returns to idle and marks the response last
   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP && out_free && remain_ff == pid_pkg::cnt_type'(1))
      |=> (state_ff == ST_IDLE && rsp_tvalid && rsp_tlast))
      else $error("dump did not end cleanly");

   // A dump never leaves the list count changed
   a_dump_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |=> $stable(count_ff))
      else $error("count changed during dump");
`endif

endmodule

>>> sim/tb_positional_insert_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_insert_deque: self-checking bench for the positional insert deque
// Drives operations on the request stream: a short table first, then random
// grow, shrink and mixed runs. Each accepted request is played through a
// queue-based predictor. Each response is checked field by field against the
// oldest expected one. Sender gaps, receiver stalls and a long receiver
// hold-off vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_positional_insert_deque;

   // No-op code: the only mode value that the package leaves unnamed
   localparam logic [2:0] MODE_NOP = 3'd7;

   localparam int QUIET_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int DRAIN_CYCLES    = 2 * pid_pkg::CAPACITY + 8;
   localparam int PHASE_ITEMS     = 40;

   typedef struct packed {
      logic [1:0]        status;
      pid_pkg::word_type word;
      logic              last;
      pid_pkg::ent_type  entries;
   } reply_type;

   typedef struct packed {
      logic       on;
      reply_type  reply;
   } fixed_reply_type;

   typedef struct packed {
      logic [2:0]        mode;
      pid_pkg::word_type value;
      logic [5:0]        index;
      logic              fixed;
      logic [1:0]        status;
      pid_pkg::word_type word;
      pid_pkg::ent_type  entries;
   } dir_row_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [pid_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [pid_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;

   // Predictor state and expected responses
   pid_pkg::word_type deque_words[$];
   reply_type         step_replies[$];
   reply_type         awaited_replies[$];
   fixed_reply_type   fixed_replies[$];

   int errors        = 0;
   int gen_count     = 0;
   int items_sent    = 0;
   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   bit hold_request  = 1'b0;

   // Directed table: typed expectations only where they are obvious
   dir_row_type dir_rows [22] = '{
      {pid_pkg::MODE_POP_HEAD,  32'h0, 6'd0,  1'b1, pid_pkg::STATUS_EMPTY, 32'h0, 6'd0},
      {pid_pkg::MODE_POP_TAIL,  32'h0, 6'd0,  1'b1, pid_pkg::STATUS_EMPTY, 32'h0, 6'd0},
      {pid_pkg::MODE_DUMP,      32'h0, 6'd0,  1'b1, pid_pkg::STATUS_EMPTY, 32'h0, 6'd0},
      {pid_pkg::MODE_INSERT,    32'h0000_0005, 6'd1,  1'b1, pid_pkg::STATUS_INDEX, 32'h0, 6'd0},
      {pid_pkg::MODE_INSERT,    32'h7FFF_FFFF, 6'd0,  1'b1, pid_pkg::STATUS_OK, 32'h0, 6'd1},
      {pid_pkg::MODE_PUSH_HEAD, 32'h8000_0000, 6'd0,  1'b1, pid_pkg::STATUS_OK, 32'h0, 6'd2},
      {pid_pkg::MODE_PUSH_TAIL, 32'hFFFF_FFFF, 6'd63, 1'b1, pid_pkg::STATUS_OK, 32'h0, 6'd3},
      {pid_pkg::MODE_INSERT,    32'h1234_5678, 6'd2,  1'b0, pid_pkg::STATUS_OK, 32'h0, 6'd0},
      {pid_pkg::MODE_INSERT,    32'h0000_0001, 6'd63, 1'b1, pid_pkg::STATUS_INDEX, 32'h0, 6'd4},
      {pid_pkg::MODE_INSERT,    32'h0000_0002, 6'd5,  1'b1, pid_pkg::STATUS_INDEX, 32'h0, 6'd4},
      {pid_pkg::MODE_INSERT,    32'h0000_0003, 6'd32, 1'b1, pid_pkg::STATUS_INDEX, 32'h0, 6'd4},
      {MODE_NOP,                32'hDEAD_BEEF, 6'd21, 1'b1, pid_pkg::STATUS_OK, 32'h0, 6'd4},
      {pid_pkg::MODE_DUMP,      32'h0, 6'd0,  1'b0, pid_pkg::STATUS_OK,    32'h0, 6'd0},
      {pid_pkg::MODE_POP_HEAD,  32'h0, 6'd0,  1'b0, pid_pkg::STATUS_OK,    32'h0, 6'd0},
      {pid_pkg::MODE_POP_TAIL,  32'h0, 6'd0,  1'b0, pid_pkg::STATUS_OK,    32'h0, 6'd0},
      {pid_pkg::MODE_INSERT,    32'h5555_5555, 6'd1,  1'b0, pid_pkg::STATUS_OK, 32'h0, 6'd0},
      {pid_pkg::MODE_DUMP,      32'h0, 6'd0,  1'b0, pid_pkg::STATUS_OK,    32'h0, 6'd0},
      {pid_pkg::MODE_CLEAR,     32'h0, 6'd0,  1'b1, pid_pkg::STATUS_OK,    32'h0, 6'd0},
      {pid_pkg::MODE_DUMP,      32'h0, 6'd0,  1'b1, pid_pkg::STATUS_EMPTY, 32'h0, 6'd0},
      {pid_pkg::MODE_PUSH_TAIL, 32'hAAAA_AAAA, 6'd0,  1'b1, pid_pkg::STATUS_OK, 32'h0, 6'd1},
      {pid_pkg::MODE_POP_TAIL,  32'h0, 6'd0,  1'b1, pid_pkg::STATUS_OK, 32'hAAAA_AAAA, 6'd0},
      {pid_pkg::MODE_POP_HEAD,  32'h0, 6'd0,  1'b1, pid_pkg::STATUS_EMPTY, 32'h0, 6'd0}
   };

   positional_insert_deque dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Queue one predicted response, tagged with the count after the operation
   function automatic void add_reply(logic [1:0] status, pid_pkg::word_type word,
                                     logic last);
      reply_type r;
      r.status  = status;
      r.word    = word;
      r.last    = last;
      r.entries = pid_pkg::ent_type'(deque_words.size());
      step_replies.push_back(r);
   endfunction

   // Apply one operation to the predicted list and collect its responses
   function automatic void apply_deque_op(logic [2:0] mode, pid_pkg::word_type value,
                                          logic [5:0] index);
      pid_pkg::word_type w;
      step_replies.delete();
      case (mode) inside
         pid_pkg::MODE_PUSH_TAIL, pid_pkg::MODE_PUSH_HEAD, pid_pkg::MODE_INSERT: begin
            // fullness wins over a bad index
            if (deque_words.size() >= pid_pkg::CAPACITY) begin
               add_reply(pid_pkg::STATUS_FULL, '0, 1'b1);
            end else if (mode == pid_pkg::MODE_INSERT &&
                         int'(index) > deque_words.size()) begin
               add_reply(pid_pkg::STATUS_INDEX, '0, 1'b1);
            end else begin
               if (mode == pid_pkg::MODE_PUSH_TAIL) deque_words.push_back(value);
               else if (mode == pid_pkg::MODE_PUSH_HEAD) deque_words.push_front(value);
               else deque_words.insert(int'(index), value);
               add_reply(pid_pkg::STATUS_OK, '0, 1'b1);
            end
         end
         pid_pkg::MODE_POP_HEAD: begin
            if (deque_words.size() == 0) begin
               add_reply(pid_pkg::STATUS_EMPTY, '0, 1'b1);
            end else begin
               w = deque_words.pop_front();
               add_reply(pid_pkg::STATUS_OK, w, 1'b1);
            end
         end
         pid_pkg::MODE_POP_TAIL: begin
            if (deque_words.size() == 0) begin
               add_reply(pid_pkg::STATUS_EMPTY, '0, 1'b1);
            end else begin
               w = deque_words.pop_back();
               add_reply(pid_pkg::STATUS_OK, w, 1'b1);
            end
         end
         pid_pkg::MODE_CLEAR: begin
            deque_words.delete();
            add_reply(pid_pkg::STATUS_OK, '0, 1'b1);
         end
         pid_pkg::MODE_DUMP: begin
            if (deque_words.size() == 0) begin
               add_reply(pid_pkg::STATUS_EMPTY, '0, 1'b1);
            end else begin
               foreach (deque_words[i])
                  add_reply(pid_pkg::STATUS_OK, deque_words[i],
                            i == deque_words.size() - 1);
            end
         end
         default: begin
            add_reply(pid_pkg::STATUS_OK, '0, 1'b1);
         end
      endcase
   endfunction

   // Track the entry count on the stimulus side to steer the random runs
   function automatic void track_count(logic [2:0] mode, logic [5:0] index);
      case (mode) inside
         pid_pkg::MODE_PUSH_TAIL, pid_pkg::MODE_PUSH_HEAD:
            if (gen_count < pid_pkg::CAPACITY) gen_count++;
         pid_pkg::MODE_INSERT:
            if (gen_count < pid_pkg::CAPACITY && int'(index) <= gen_count) gen_count++;
         pid_pkg::MODE_POP_HEAD, pid_pkg::MODE_POP_TAIL:
            if (gen_count > 0) gen_count--;
         pid_pkg::MODE_CLEAR: gen_count = 0;
         default: ;
      endcase
   endfunction

   function automatic pid_pkg::word_type pick_word();
      case ($urandom_range(15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [2:0] pick_push_mode();
      case ($urandom_range(2))
         0: return pid_pkg::MODE_PUSH_TAIL;
         1: return pid_pkg::MODE_PUSH_HEAD;
         default: return pid_pkg::MODE_INSERT;
      endcase
   endfunction

   // Offer one request, with a random gap first, and hold it until accepted
   task automatic send_item(logic [2:0] mode, pid_pkg::word_type value,
                            logic [5:0] index, fixed_reply_type fx);
      fixed_replies.push_back(fx);
      track_count(mode, index);
      items_sent++;
      if ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, index, value, mode};  // zero pad, index, value, mode
      do @(posedge clock); while (!req_tready);
   endtask

   // Fill toward a target, often all the way, then overflow when full and dump
   task automatic grow_run();
      int target;
      target = $urandom_range(1) ? pid_pkg::CAPACITY
                                 : $urandom_range(pid_pkg::CAPACITY, gen_count);
      while (gen_count < target)
         send_item(pick_push_mode(), pick_word(), 6'($urandom_range(gen_count)), '0);
      if (gen_count == pid_pkg::CAPACITY) begin
         repeat (2) send_item(pick_push_mode(), pick_word(), 6'($urandom_range(63)), '0);
      end
      send_item(pid_pkg::MODE_DUMP, pick_word(), 6'($urandom_range(63)), '0);
   endtask

   // Drain toward a target, often to empty, then underflow when empty and dump
   task automatic shrink_run();
      int target;
      target = $urandom_range(1) ? 0 : $urandom_range(gen_count);
      while (gen_count > target)
         send_item($urandom_range(1) ? pid_pkg::MODE_POP_HEAD : pid_pkg::MODE_POP_TAIL,
                   pick_word(), 6'($urandom_range(63)), '0);
      if (gen_count == 0)
         send_item($urandom_range(1) ? pid_pkg::MODE_POP_HEAD : pid_pkg::MODE_POP_TAIL,
                   pick_word(), 6'($urandom_range(63)), '0);
      send_item(pid_pkg::MODE_DUMP, pick_word(), 6'($urandom_range(63)), '0);
   endtask

   // Any mode, index mostly in range
   task automatic mix_run();
      logic [5:0] index;
      repeat (12) begin
         index = ($urandom_range(9) < 7) ? 6'($urandom_range(gen_count))
                                         : 6'($urandom_range(63));
         send_item(3'($urandom_range(7)), pick_word(), index, '0);
      end
   endtask

   // Predict on every accepted request transaction
   always @(posedge clock) begin
      fixed_reply_type fx;
      if (!reset && req_tvalid && req_tready) begin
         apply_deque_op(req_tdata[2:0], req_tdata[34:3], req_tdata[40:35]);
         fx = fixed_replies.pop_front();
         if (fx.on) awaited_replies.push_back(fx.reply);
         else foreach (step_replies[i]) awaited_replies.push_back(step_replies[i]);
      end
   end

   // Check every accepted response transaction against the oldest expectation
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_replies.size() == 0) begin
            $error("response with nothing expected: tdata %h last %b", rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_tdata[1:0] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
               errors++;
            end
            if (rsp_tdata[33:2] !== want.word) begin
               $error("word: expected %h, got %h", want.word, rsp_tdata[33:2]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_tlast);
               errors++;
            end
            if (rsp_tdata[39:34] !== want.entries) begin
               $error("entries: expected %0d, got %0d", want.entries, rsp_tdata[39:34]);
               errors++;
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Stimulus: reset, directed table, then random phases
   initial begin
      fixed_reply_type fx;
      int phase_end;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         fx.on            = dir_rows[i].fixed;
         fx.reply.status  = dir_rows[i].status;
         fx.reply.word    = dir_rows[i].word;
         fx.reply.last    = 1'b1;
         fx.reply.entries = dir_rows[i].entries;
         send_item(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].index, fx);
      end

      // long receiver hold-off, sender gaps, receiver stalls, then both lightly
      for (int p = 0; p < 4; p++) begin
         send_gap_pct  = (p == 1) ? 84 : (p == 3) ? 7 : 0;
         rsp_stall_pct = (p == 2) ? 84 : (p == 3) ? 7 : 0;
         if (p == 0) hold_request = 1'b1;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            case ($urandom_range(9)) inside
               [0:3]: grow_run();
               [4:6]: shrink_run();
               default: mix_run();
            endcase
         end
      end
      req_tvalid <= 1'b0;

      // Let the predictor take the final request, drain, then watch for strays
      @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && awaited_replies.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
